// File: hw/rtl/skmd_pkg.sv
package skmd_pkg;

    localparam int unsigned MAX_SYMBOLS_DEF = 8;
    localparam int unsigned DOT_W           = 11;
    localparam int unsigned TIME_W          = 32;
    localparam int unsigned CODE_W          = 7;
    localparam int unsigned LEN_W           = 4;
    localparam int unsigned PAT_W           = 5;

    localparam logic [DOT_W-1:0] DOT_RESET = 11'd60;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_DOWN = 3'b010,
        PH_WAIT = 3'b100
    } phase_t;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              key_down;
    } in_word_t;

    typedef struct packed {
        logic              tone_on;
        logic              transmit_on;
        logic              letter_valid;
        logic [CODE_W-1:0] letter_code;
        logic              space_valid;
    } out_word_t;

    // bit i of pat is symbol i, dash = 1; bits above len are zero
    function automatic logic [CODE_W-1:0] morse_lookup(
        input logic [LEN_W-1:0] len,
        input logic [PAT_W-1:0] pat
    );
        logic [CODE_W-1:0] code;
        code = '0;
        unique case ({len, pat})
            {4'd1, 5'd0}:  code = 7'h45; // E
            {4'd1, 5'd1}:  code = 7'h54; // T
            {4'd2, 5'd2}:  code = 7'h41; // A
            {4'd2, 5'd0}:  code = 7'h49; // I
            {4'd2, 5'd3}:  code = 7'h4D; // M
            {4'd2, 5'd1}:  code = 7'h4E; // N
            {4'd3, 5'd1}:  code = 7'h44; // D
            {4'd3, 5'd3}:  code = 7'h47; // G
            {4'd3, 5'd5}:  code = 7'h4B; // K
            {4'd3, 5'd7}:  code = 7'h4F; // O
            {4'd3, 5'd2}:  code = 7'h52; // R
            {4'd3, 5'd0}:  code = 7'h53; // S
            {4'd3, 5'd4}:  code = 7'h55; // U
            {4'd3, 5'd6}:  code = 7'h57; // W
            {4'd4, 5'd1}:  code = 7'h42; // B
            {4'd4, 5'd5}:  code = 7'h43; // C
            {4'd4, 5'd4}:  code = 7'h46; // F
            {4'd4, 5'd0}:  code = 7'h48; // H
            {4'd4, 5'd14}: code = 7'h4A; // J
            {4'd4, 5'd2}:  code = 7'h4C; // L
            {4'd4, 5'd6}:  code = 7'h50; // P
            {4'd4, 5'd11}: code = 7'h51; // Q
            {4'd4, 5'd8}:  code = 7'h56; // V
            {4'd4, 5'd9}:  code = 7'h58; // X
            {4'd4, 5'd13}: code = 7'h59; // Y
            {4'd4, 5'd3}:  code = 7'h5A; // Z
            {4'd5, 5'd31}: code = 7'h30;
            {4'd5, 5'd30}: code = 7'h31;
            {4'd5, 5'd28}: code = 7'h32;
            {4'd5, 5'd24}: code = 7'h33;
            {4'd5, 5'd16}: code = 7'h34;
            {4'd5, 5'd0}:  code = 7'h35;
            {4'd5, 5'd1}:  code = 7'h36;
            {4'd5, 5'd3}:  code = 7'h37;
            {4'd5, 5'd7}:  code = 7'h38;
            {4'd5, 5'd15}: code = 7'h39;
            default:       code = '0;
        endcase
        return code;
    endfunction

endpackage

// File: hw/rtl/straight_key_morse_decoder.sv
// channel  | direction | handshake         | word
// ---------+-----------+-------------------+-------------------------------
// in       | input     | in_valid/in_stall | now_ms, key_down
// out      | output    | out_valid/out_stall | tone_on .. space_valid
// cfg      | input     | cfg_valid/cfg_ready | dot_length_ms (11 bit)
//
// one word per cycle while out_stall is low; a taken word passes the input
// register, then decode and state update into the output register
// rst_n clears the key state, the pattern and dot_length_ms to 60
// out_stall holds the output register and backs up into in_stall only
// when both registers are full; cfg writes are always taken
module straight_key_morse_decoder #(
    parameter int unsigned MAX_SYMBOLS = skmd_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  skmd_pkg::in_word_t           in_data,
    output logic                         out_valid,
    input  logic                         out_stall,
    output skmd_pkg::out_word_t          out_data,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [skmd_pkg::DOT_W-1:0]   cfg_data
);

    logic                          in_vld_reg, in_vld_next;
    skmd_pkg::in_word_t            in_word_reg;
    logic                          out_vld_reg, out_vld_next;
    skmd_pkg::out_word_t           out_word_reg;
    logic [skmd_pkg::DOT_W-1:0]    dot_reg;
    logic                          advance;
    logic                          in_take;
    skmd_pkg::out_word_t           result;

    assign advance   = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall  = in_vld_reg && !advance;
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;

    assign in_vld_next  = in_take || (in_vld_reg && !advance);
    assign out_vld_next = advance || (out_vld_reg && out_stall);

    assign out_valid = out_vld_reg;
    assign out_data  = out_word_reg;

    skmd_core #(
        .MAX_SYMBOLS (MAX_SYMBOLS)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .dot_len (dot_reg),
        .item    (in_word_reg),
        .result  (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            dot_reg     <= skmd_pkg::DOT_RESET;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
            if (cfg_valid && cfg_ready)
            begin
                dot_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_word_reg <= in_data;
        end
        if (advance)
        begin
            out_word_reg <= result;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.letter_valid == (out_data.letter_code != '0)))
        else $error("letter flag and code disagree");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.tone_on |-> out_data.transmit_on)
        else $error("tone without transmit");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_data.space_valid || out_data.letter_valid) |-> !out_data.tone_on)
        else $error("decode while key down");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> in_vld_reg && out_vld_reg && out_stall)
        else $error("input stalled with room downstream");
`endif

endmodule

// File: hw/rtl/skmd_core.sv
module skmd_core #(
    parameter int unsigned MAX_SYMBOLS = skmd_pkg::MAX_SYMBOLS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  logic [skmd_pkg::DOT_W-1:0]     dot_len,
    input  skmd_pkg::in_word_t             item,
    output skmd_pkg::out_word_t            result
);

    localparam int unsigned CNT_W = $clog2(MAX_SYMBOLS + 1);
    localparam int unsigned IDX_W = $clog2(MAX_SYMBOLS);

    skmd_pkg::phase_t                  phase_reg, phase_next;
    logic [skmd_pkg::TIME_W-1:0]       start_reg, start_next;
    logic [CNT_W-1:0]                  count_reg, count_next;
    logic [MAX_SYMBOLS-1:0]            bits_reg, bits_next;

    logic [skmd_pkg::TIME_W-1:0]       elapsed;
    logic [skmd_pkg::DOT_W+1:0]        dot2, dot3;
    logic [skmd_pkg::DOT_W+2:0]        dot4, dot7;
    logic                              is_dash, ge3, ge4, ge7;
    logic [skmd_pkg::CODE_W-1:0]       lookup;
    logic [skmd_pkg::CODE_W-1:0]       letter;
    logic                              space;

    assign elapsed = item.now_ms - start_reg;
    assign dot2 = {1'b0, dot_len, 1'b0};
    assign dot3 = {2'b00, dot_len} + {1'b0, dot_len, 1'b0};
    assign dot4 = {1'b0, dot_len, 2'b00};
    assign dot7 = {dot_len, 3'b000} - {3'b000, dot_len};

    assign is_dash = elapsed >= {{(skmd_pkg::TIME_W-skmd_pkg::DOT_W-2){1'b0}}, dot2};
    assign ge3     = elapsed >= {{(skmd_pkg::TIME_W-skmd_pkg::DOT_W-2){1'b0}}, dot3};
    assign ge4     = elapsed >= {{(skmd_pkg::TIME_W-skmd_pkg::DOT_W-3){1'b0}}, dot4};
    assign ge7     = elapsed >= {{(skmd_pkg::TIME_W-skmd_pkg::DOT_W-3){1'b0}}, dot7};

    // patterns longer than the table never match
    assign lookup = (count_reg > CNT_W'(skmd_pkg::PAT_W)) ? '0 :
        skmd_pkg::morse_lookup(skmd_pkg::LEN_W'(count_reg),
                               bits_reg[skmd_pkg::PAT_W-1:0]);

    always_comb
    begin
        phase_next = phase_reg;
        start_next = start_reg;
        count_next = count_reg;
        bits_next  = bits_reg;
        letter     = '0;
        space      = 1'b0;
        unique case (phase_reg)
            skmd_pkg::PH_DOWN:
            begin
                if (!item.key_down)
                begin
                    if (count_reg < CNT_W'(MAX_SYMBOLS))
                    begin
                        bits_next[count_reg[IDX_W-1:0]] = bits_reg[count_reg[IDX_W-1:0]]
                                                          | is_dash;
                        count_next = count_reg + 1'b1;
                    end
                    phase_next = skmd_pkg::PH_WAIT;
                    start_next = item.now_ms;
                end
            end
            skmd_pkg::PH_WAIT:
            begin
                if (item.key_down)
                begin
                    phase_next = skmd_pkg::PH_DOWN;
                    start_next = item.now_ms;
                end
                else
                begin
                    // any gap of three dots or more decodes once and clears
                    if (ge3)
                    begin
                        letter     = lookup;
                        count_next = '0;
                        bits_next  = '0;
                    end
                    space = ge7;
                    if (ge4)
                    begin
                        phase_next = skmd_pkg::PH_IDLE;
                    end
                end
            end
            default:
            begin
                phase_next = skmd_pkg::PH_IDLE;
                if (item.key_down)
                begin
                    phase_next = skmd_pkg::PH_DOWN;
                    start_next = item.now_ms;
                end
            end
        endcase
    end

    always_comb
    begin
        result.tone_on      = (phase_next == skmd_pkg::PH_DOWN);
        result.transmit_on  = (phase_next != skmd_pkg::PH_IDLE);
        result.letter_valid = (letter != '0);
        result.letter_code  = letter;
        result.space_valid  = space;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= skmd_pkg::PH_IDLE;
            start_reg <= '0;
            count_reg <= '0;
            bits_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            start_reg <= start_next;
            count_reg <= count_next;
            bits_reg  <= bits_next;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_SYMBOLS))
        else $error("symbol count beyond limit");

    assert property (@(posedge clk) disable iff (!rst_n)
        step && result.letter_valid |=> count_reg == '0)
        else $error("pattern not cleared after decode");

    assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == skmd_pkg::PH_DOWN && !item.key_down
        |=> phase_reg == skmd_pkg::PH_WAIT)
        else $error("key release did not enter wait");
`endif

endmodule

// File: dv/straight_key_morse_decoder_tb.sv
module straight_key_morse_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import skmd_pkg::*;

    localparam int MAX_SYM     = MAX_SYMBOLS_DEF;
    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE      = 10;
    localparam int NUM_CHARS   = 36;
    localparam string MORSE_CHARS = "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789";

    string morse_pat [NUM_CHARS] = '{
        ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
        "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
        "..-", "...-", ".--", "-..-", "-.--", "--..", "-----", ".----", "..---",
        "...--", "....-", ".....", "-....", "--...", "---..", "----."
    };

    logic              clk = 1'b0;
    logic              rst_n;
    logic              in_valid;
    logic              in_stall;
    in_word_t          in_data;
    logic              out_valid;
    logic              out_stall;
    out_word_t         out_data;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [DOT_W-1:0]  cfg_data;

    // decoder state as the block should hold it
    logic [DOT_W-1:0]  dot_len    = DOT_RESET;
    phase_t            key_phase  = PH_IDLE;
    logic [31:0]       mark_start = '0;
    int                sym_count  = 0;
    logic [7:0]        sym_bits   = '0;

    out_word_t         predicted_out [$];
    logic [31:0]       now_cursor;
    bit                tx_gaps_on;
    bit                rx_stalls_on;
    int                rx_wait;
    int                hold_req;
    int                error_count;
    int                items_sent;
    int                words_checked;
    int                letters_seen;
    int                spaces_seen;
    int                cfg_writes;

    straight_key_morse_decoder u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int span(input int lo, input int hi);
        if (hi <= lo)
            return lo;
        return int'($urandom_range(hi, lo));
    endfunction

    // matches the kept symbols against the table, then clears them
    function automatic logic [CODE_W-1:0] take_letter();
        logic [CODE_W-1:0] found;
        string             pat;
        bit                same;
        found = '0;
        for (int e = 0; e < NUM_CHARS && found == 0; e++)
        begin
            pat = morse_pat[e];
            if (pat.len() == sym_count)
            begin
                same = 1'b1;
                for (int i = 0; i < pat.len(); i++)
                    if ((pat[i] == "-") != sym_bits[i])
                        same = 1'b0;
                if (same)
                    found = CODE_W'(MORSE_CHARS[e]);
            end
        end
        sym_count = 0;
        sym_bits  = '0;
        return found;
    endfunction

    function automatic out_word_t decode_step(input in_word_t w);
        out_word_t         r;
        logic [31:0]       dot32;
        logic [31:0]       span_ms;
        logic [CODE_W-1:0] letter;
        bit                space;
        dot32  = {{(32-DOT_W){1'b0}}, dot_len};
        letter = '0;
        space  = 1'b0;
        case (key_phase)
            PH_DOWN:
            begin
                if (!w.key_down)
                begin
                    span_ms = w.now_ms - mark_start;
                    if (sym_count < MAX_SYM && sym_count < 8)
                    begin
                        if (!(span_ms < dot32 * 2))
                            sym_bits[sym_count] = 1'b1;
                        sym_count++;
                    end
                    key_phase  = PH_WAIT;
                    mark_start = w.now_ms;
                end
            end
            PH_WAIT:
            begin
                if (w.key_down)
                begin
                    key_phase  = PH_DOWN;
                    mark_start = w.now_ms;
                end
                else
                begin
                    span_ms = w.now_ms - mark_start;
                    if (span_ms >= dot32 * 3 && span_ms < dot32 * 7)
                        letter = take_letter();
                    if (span_ms >= dot32 * 7)
                    begin
                        letter = take_letter();
                        space  = 1'b1;
                    end
                    if (span_ms >= dot32 * 4)
                        key_phase = PH_IDLE;
                end
            end
            default:
            begin
                key_phase = PH_IDLE;
                if (w.key_down)
                begin
                    key_phase  = PH_DOWN;
                    mark_start = w.now_ms;
                end
            end
        endcase
        r.tone_on      = (key_phase == PH_DOWN);
        r.transmit_on  = (key_phase != PH_IDLE);
        r.letter_valid = (letter != 0);
        r.letter_code  = letter;
        r.space_valid  = space;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // valid stays high across back-to-back words, dropped only for a gap
    task automatic send_word(input in_word_t w);
        int gap;
        gap = tx_gaps_on ? int'($urandom_range(0, 7)) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predicted_out.push_back(decode_step(w));
        items_sent++;
    endtask

    task automatic send_key(input logic [31:0] t, input bit key);
        in_word_t w;
        w.now_ms   = t;
        w.key_down = key;
        send_word(w);
    endtask

    task automatic drain_words();
        in_valid <= 1'b0;
        while (predicted_out.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_dot(input logic [DOT_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        dot_len = v;
        cfg_writes++;
    endtask

    // keys one symbol pattern with random timing, then a random letter or word gap
    task automatic key_pattern(input string pat);
        int d;
        int mark;
        int gap;
        d = int'(dot_len);
        for (int i = 0; i < pat.len(); i++)
        begin
            mark = (pat[i] == "-") ? span(2 * d, 5 * d) : span(0, 2 * d - 1);
            send_key(now_cursor, 1'b1);
            if ($urandom_range(0, 3) == 0)
                send_key(now_cursor + 32'(span(0, mark)), 1'b1);
            now_cursor += 32'(mark);
            send_key(now_cursor, 1'b0);
            if (i + 1 < pat.len())
            begin
                gap = span(0, 3 * d - 1);
                if ($urandom_range(0, 2) == 0)
                    send_key(now_cursor + 32'(span(0, gap)), 1'b0);
                now_cursor += 32'(gap);
            end
        end
        case ($urandom_range(0, 3))
            0:
            begin
                // decode but keep waiting, then a late sample sees nothing left
                send_key(now_cursor + 32'(span(3 * d, 4 * d - 1)), 1'b0);
                send_key(now_cursor + 32'(span(4 * d, 9 * d)), 1'b0);
            end
            1: send_key(now_cursor + 32'(span(4 * d, 7 * d - 1)), 1'b0);
            default: send_key(now_cursor + 32'(span(7 * d, 9 * d)), 1'b0);
        endcase
        now_cursor += 32'(10 * d + span(0, 50));
    endtask

    function automatic string random_pattern();
        string pat;
        int    n;
        pat = "";
        n   = span(1, 9);
        for (int i = 0; i < n; i++)
            pat = {pat, ($urandom_range(0, 1) != 0) ? "-" : "."};
        return pat;
    endfunction

    // wrap of the time base, dot/dash boundary, repeated decode, space alone
    task automatic test_directed_timing();
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        send_key(32'h0000_0000, 1'b0);
        send_key(32'hFFFF_FFF0, 1'b1);
        send_key(32'h0000_0010, 1'b0);
        send_key(32'h0000_0010 + 200, 1'b0);
        send_key(32'h0000_0010 + 230, 1'b0);
        send_key(32'h0000_0010 + 500, 1'b0);
        send_key(32'h0000_1000, 1'b1);
        send_key(32'h0000_1000 + 120, 1'b0);
        send_key(32'h0000_1000 + 120 + 179, 1'b0);
        send_key(32'h0000_1000 + 120 + 420, 1'b0);
        send_key(32'hFFFF_FFFF, 1'b1);
        send_key(32'hFFFF_FFFF + 119, 1'b0);
        send_key(32'hFFFF_FFFF + 119 + 240, 1'b0);
        drain_words();
    endtask

    // zero dot length makes every mark a dash; nine marks overflow the pattern
    task automatic test_zero_dot_overflow();
        write_dot('0);
        for (int i = 0; i < 9; i++)
        begin
            send_key(32'(i * 16), 1'b1);
            send_key(32'(i * 16 + 3), 1'b0);
        end
        send_key(32'h7FFF_FFFF, 1'b0);
        drain_words();
    endtask

    task automatic test_random_traffic();
        logic [DOT_W-1:0] dots [10];
        int               target;
        dots[0] = 11'd1;
        dots[1] = 11'd1200;
        dots[2] = {DOT_W{1'b1}};
        dots[3] = '0;
        for (int p = 4; p < 8; p++)
            dots[p] = DOT_W'($urandom_range(1, 20));
        for (int p = 8; p < 10; p++)
            dots[p] = DOT_W'($urandom_range(21, 1200));
        for (int p = 0; p < 10; p++)
        begin
            write_dot(dots[p]);
            tx_gaps_on   = (p % 4 == 0) || (p % 4 == 1);
            rx_stalls_on = (p % 4 == 0) || (p % 4 == 2);
            now_cursor   = $urandom();
            target       = items_sent + 140;
            while (items_sent < target)
            begin
                case ($urandom_range(0, 9))
                    0: send_key($urandom(), 1'($urandom_range(0, 1)));
                    1: send_key(now_cursor + 32'(span(0, 10 * int'(dot_len))),
                                1'($urandom_range(0, 1)));
                    2, 3: key_pattern(random_pattern());
                    default: key_pattern(morse_pat[$urandom_range(0, NUM_CHARS - 1)]);
                endcase
            end
            drain_words();
        end
    endtask

    // receiver holds off while words keep coming so the block backs up
    task automatic test_backpressure();
        write_dot(11'd5);
        tx_gaps_on   = 1'b0;
        rx_stalls_on = 1'b0;
        hold_req     = 80;
        now_cursor   = $urandom();
        while (hold_req != 0 || rx_wait > 20)
            key_pattern(morse_pat[$urandom_range(0, NUM_CHARS - 1)]);
        drain_words();
    endtask

    initial
    begin : receiver
        rx_wait  = 0;
        hold_req = 0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
                rx_wait = rx_stalls_on ? int'($urandom_range(0, 7)) : 0;
            else if (rx_wait > 0)
                rx_wait--;
            if (hold_req > 0)
            begin
                rx_wait  = hold_req;
                hold_req = 0;
            end
            out_stall <= (rx_wait > 0);
        end
    end

    initial
    begin : result_check
        out_word_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                if (predicted_out.size() == 0)
                    report_mismatch($sformatf("word %h with nothing pending", out_data));
                else
                begin
                    want = predicted_out.pop_front();
                    if (out_data.tone_on !== want.tone_on)
                        report_mismatch($sformatf("word %0d tone_on got %b want %b",
                            words_checked, out_data.tone_on, want.tone_on));
                    if (out_data.transmit_on !== want.transmit_on)
                        report_mismatch($sformatf("word %0d transmit_on got %b want %b",
                            words_checked, out_data.transmit_on, want.transmit_on));
                    if (out_data.letter_valid !== want.letter_valid)
                        report_mismatch($sformatf("word %0d letter_valid got %b want %b",
                            words_checked, out_data.letter_valid, want.letter_valid));
                    if (out_data.letter_code !== want.letter_code)
                        report_mismatch($sformatf("word %0d letter_code got %h want %h",
                            words_checked, out_data.letter_code, want.letter_code));
                    if (out_data.space_valid !== want.space_valid)
                        report_mismatch($sformatf("word %0d space_valid got %b want %b",
                            words_checked, out_data.space_valid, want.space_valid));
                    if (want.letter_valid)
                        letters_seen++;
                    if (want.space_valid)
                        spaces_seen++;
                end
                words_checked++;
            end
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        error_count   = 0;
        items_sent    = 0;
        words_checked = 0;
        letters_seen  = 0;
        spaces_seen   = 0;
        cfg_writes    = 0;
        tx_gaps_on    = 1'b0;
        rx_stalls_on  = 1'b0;
        now_cursor    = '0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_timing();
        test_zero_dot_overflow();
        test_random_traffic();
        test_backpressure();

        repeat (SETTLE) @(posedge clk);
        if (predicted_out.size() != 0)
            report_mismatch($sformatf("%0d words never arrived", predicted_out.size()));
        $display("sent %0d key samples across %0d dot length settings", items_sent,
                 cfg_writes + 1);
        $display("checked %0d words: %0d characters and %0d word spaces decoded",
                 words_checked, letters_seen, spaces_seen);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/skmd_pkg.sv
hw/rtl/skmd_core.sv
hw/rtl/straight_key_morse_decoder.sv
dv/straight_key_morse_decoder_tb.sv
